>>> rtl/core/strrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strrb_pkg
// Command codes and control bundles shared by the serial ring buffer block.
// ----------------------------------------------------------------------------
package strrb_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT_TX   = 3'd0,
    CMD_TX_READY = 3'd1,
    CMD_RX_BYTE  = 3'd2,
    CMD_GET_RX   = 3'd3,
    CMD_FLUSH_RX = 3'd4,
    CMD_FLUSH_TX = 3'd5
  } cmd_t;

  // Per-cycle request into one ring
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } ring_ctl_t;

  // Occupancy status out of one ring
  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

endpackage : strrb_pkg
`default_nettype wire

>>> rtl/core/strrb_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strrb_ring
// One byte ring buffer: synchronous store with registered read data, read and
// write pointers and a fill count. With OVERWRITE set, a push into a full ring
// replaces the oldest byte; otherwise it is dropped.
// ----------------------------------------------------------------------------
module strrb_ring
  import strrb_pkg::*;
#(
  parameter int unsigned DEPTH     = 8,
  parameter bit          OVERWRITE = 1'b0,
  localparam int unsigned PTR_W    = $clog2(DEPTH),
  localparam int unsigned FILL_W   = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ring_ctl_t         ctl,
  input  wire logic [BYTE_W-1:0] wr_data,
  output logic      [BYTE_W-1:0] rd_data,
  output logic      [FILL_W-1:0] fill,
  output ring_stat_t             stat
);

  logic [BYTE_W-1:0] mem [DEPTH];

  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [FILL_W-1:0] fill_next;
  logic              do_write, do_read;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign stat.full  = (fill == FILL_W'(DEPTH));
  assign stat.empty = (fill == '0);

  assign do_write = ctl.push && (!stat.full || OVERWRITE);
  assign do_read  = ctl.pop && !stat.empty;

  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    fill_next   = fill;
    if (ctl.flush) begin
      rd_ptr_next = '0;
      wr_ptr_next = '0;
      fill_next   = '0;
    end else if (do_write) begin
      wr_ptr_next = bump(wr_ptr);
      if (stat.full) begin
        // drop the oldest byte, whose slot the new byte overwrites
        rd_ptr_next = bump(rd_ptr);
      end else begin
        fill_next = fill + FILL_W'(1);
      end
    end else if (do_read) begin
      rd_ptr_next = bump(rd_ptr);
      fill_next   = fill - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      fill   <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      rd_data <= mem[rd_ptr];
    end
  end

endmodule : strrb_ring
`default_nettype wire

>>> rtl/core/serial_tx_rx_ring_buffers.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_tx_rx_ring_buffers
// Transmit and receive byte ring buffers for a serial port, one command per
// transaction.
// ----------------------------------------------------------------------------
// Each command is taken on a cycle with start high and busy low; busy never
// rises, so a command may be issued every cycle. Its result appears on the
// following cycle for that one cycle only, marked by done, and the receiver
// cannot stall it. The delay comes from the registered read port of
// each buffer store. Levels are those after the command. Flushes reset the
// pointers and count only; stale bytes are never returned.
module serial_tx_rx_ring_buffers
  import strrb_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 8,
  localparam int unsigned LEVEL_W     = $clog2(BUFFER_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [CMD_W-1:0]   command,
  input  wire logic [BYTE_W-1:0]  in_byte,
  output logic                    done,
  output logic      [BYTE_W-1:0]  out_byte,
  output logic                    out_valid,
  output logic                    accepted,
  output logic                    tx_idle,
  output logic                    rx_overrun,
  output logic      [LEVEL_W-1:0] tx_level,
  output logic      [LEVEL_W-1:0] rx_level
);

  ring_ctl_t         tx_ctl, rx_ctl;
  ring_stat_t        tx_stat, rx_stat;
  logic [BYTE_W-1:0] tx_rd_data, rx_rd_data;
  logic              take;

  logic done_next, valid_next, accepted_next, tx_idle_next, overrun_next, sel_rx_next;
  logic sel_rx;

  assign busy = 1'b0;
  assign take = start && !busy;

  always_comb begin
    tx_ctl        = '0;
    rx_ctl        = '0;
    done_next     = take;
    valid_next    = 1'b0;
    accepted_next = 1'b0;
    tx_idle_next  = 1'b0;
    overrun_next  = 1'b0;
    sel_rx_next   = 1'b0;
    if (take) begin
      case (cmd_t'(command))
        CMD_PUT_TX: begin
          tx_ctl.push   = 1'b1;
          accepted_next = !tx_stat.full;
        end
        CMD_TX_READY: begin
          tx_ctl.pop   = 1'b1;
          valid_next   = !tx_stat.empty;
          tx_idle_next = tx_stat.empty;
        end
        CMD_RX_BYTE: begin
          rx_ctl.push  = 1'b1;
          overrun_next = rx_stat.full;
        end
        CMD_GET_RX: begin
          rx_ctl.pop  = 1'b1;
          valid_next  = !rx_stat.empty;
          sel_rx_next = 1'b1;
        end
        CMD_FLUSH_RX: rx_ctl.flush = 1'b1;
        CMD_FLUSH_TX: tx_ctl.flush = 1'b1;
        default: ;
      endcase
    end
  end

  strrb_ring #(
    .DEPTH     (BUFFER_DEPTH),
    .OVERWRITE (1'b0)
  ) u_tx_ring (
    .clk     (clk),
    .rst     (rst),
    .ctl     (tx_ctl),
    .wr_data (in_byte),
    .rd_data (tx_rd_data),
    .fill    (tx_level),
    .stat    (tx_stat)
  );

  strrb_ring #(
    .DEPTH     (BUFFER_DEPTH),
    .OVERWRITE (1'b1)
  ) u_rx_ring (
    .clk     (clk),
    .rst     (rst),
    .ctl     (rx_ctl),
    .wr_data (in_byte),
    .rd_data (rx_rd_data),
    .fill    (rx_level),
    .stat    (rx_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      out_valid  <= 1'b0;
      accepted   <= 1'b0;
      tx_idle    <= 1'b0;
      rx_overrun <= 1'b0;
      sel_rx     <= 1'b0;
    end else begin
      done       <= done_next;
      out_valid  <= valid_next;
      accepted   <= accepted_next;
      tx_idle    <= tx_idle_next;
      rx_overrun <= overrun_next;
      sel_rx     <= sel_rx_next;
    end
  end

  // read data lands in the cycle after the transaction; zero it when unused
  assign out_byte = !out_valid ? '0 : (sel_rx ? rx_rd_data : tx_rd_data);

`ifndef SYNTH
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    start |=> done) else $error("result strobe missing after command");

  a_accept_has_level: assert property (@(posedge clk) disable iff (rst)
    (done && accepted) |-> (tx_level != '0)) else $error("accepted put left tx empty");

  a_idle_excl_valid: assert property (@(posedge clk) disable iff (rst)
    (done && tx_idle) |-> (!out_valid && tx_level == '0))
    else $error("tx idle reported with data");

  a_overrun_full: assert property (@(posedge clk) disable iff (rst)
    (done && rx_overrun) |-> (rx_level == LEVEL_W'(BUFFER_DEPTH)))
    else $error("rx overrun without full buffer");

  a_levels_bounded: assert property (@(posedge clk) disable iff (rst)
    (tx_level <= LEVEL_W'(BUFFER_DEPTH)) && (rx_level <= LEVEL_W'(BUFFER_DEPTH)))
    else $error("buffer level out of range");
`endif

endmodule : serial_tx_rx_ring_buffers
`default_nettype wire
